// ===== sv/frf_pkg.sv =====
// ----------------------------------------------------------------------------
// frf_pkg
// Shared widths, register codes, types and the force clip function for the
// fence repel force pipeline.
// ----------------------------------------------------------------------------
package frf_pkg;

    // field widths
    localparam int IdW    = 16;
    localparam int PosW   = 24;
    localparam int WtW    = 16;
    localparam int RadW   = 23;
    localparam int BndW   = 48;
    localparam int ForceW = 32;

    // datapath widths
    localparam int DW      = PosW + 1;          // offset from center, signed
    localparam int SqW     = 2 * DW;            // sum of squares
    localparam int RtSteps = SqW / 2;           // root bits produced
    localparam int RtW     = SqW + 1;           // root work register
    localparam int DistW   = RtSteps + 1;       // distance
    localparam int DenW    = 2 * DistW;         // dist * (dist - rad)
    localparam int ProdW   = DW + WtW;          // |d| * weight
    localparam int FracSh  = 16;                // Q12.12 * Q8.8 / Q24.24 scaling
    localparam int NumW    = ProdW + FracSh;    // dividend
    localparam int QW      = ForceW + 1;        // quotient bits kept
    localparam int CubSh   = 8;                 // Q8.8 weight scaling

    // configuration port
    localparam int AddrW = 6;
    localparam int DataW = 64;

    localparam logic [2:0] REG_MODE   = 3'd0;
    localparam logic [2:0] REG_ID     = 3'd1;
    localparam logic [2:0] REG_WEIGHT = 3'd2;
    localparam logic [2:0] REG_RAD    = 3'd3;
    localparam logic [2:0] REG_BX     = 3'd4;
    localparam logic [2:0] REG_BY     = 3'd5;
    localparam logic [2:0] REG_BZ     = 3'd6;

    localparam logic MODE_SPHERE = 1'b0;
    localparam logic MODE_CUBOID = 1'b1;

    localparam logic [WtW-1:0]    WEIGHT_RST = 16'h0100;
    localparam logic [ForceW-1:0] FMAX       = 32'h7FFF_FFFF;
    localparam logic [ForceW-1:0] FMIN       = 32'h8000_0000;

    typedef struct packed {
        logic                     mode;
        logic [IdW-1:0]           id;
        logic [WtW-1:0]           weight;
        logic [RadW-1:0]          rad;
        logic [2:0][BndW-1:0]     bnd;
    } cfg_t;

    // data that rides along the root and divide stages
    typedef struct packed {
        logic                     sphere;   // sphere path live for this item
        logic [2:0]               neg;      // offset positive: force negative
        logic [2:0][DW-1:0]       mag;      // |offset| per axis
        logic [2:0][ForceW-1:0]   frc;      // cuboid or zero result
        logic                     sat;
    } side_t;

    // magnitude plus sign to saturated word; top bit is the clip flag
    function automatic logic [ForceW:0] clip_force(input logic [QW-1:0] mag,
                                                   input logic ovf,
                                                   input logic neg);
        logic [ForceW:0] r;
        if (neg) begin
            if (ovf || mag > QW'(FMIN))
                r = {1'b1, FMIN};
            else
                r = {1'b0, (~mag[ForceW-1:0]) + 1'b1};
        end else begin
            if (ovf || mag > QW'(FMAX))
                r = {1'b1, FMAX};
            else
                r = {1'b0, mag[ForceW-1:0]};
        end
        return r;
    endfunction

endpackage

// ===== sv/frf_in_if.sv =====
// ----------------------------------------------------------------------------
// frf_in_if
// Agent channel: id and position, valid/ready handshake.
// ----------------------------------------------------------------------------
interface frf_in_if;
    logic                            valid;
    logic                            ready;
    logic [frf_pkg::IdW-1:0]         agent_id;
    logic signed [frf_pkg::PosW-1:0] pos_x;
    logic signed [frf_pkg::PosW-1:0] pos_y;
    logic signed [frf_pkg::PosW-1:0] pos_z;

    modport source (output valid, agent_id, pos_x, pos_y, pos_z, input ready);
    modport sink   (input valid, agent_id, pos_x, pos_y, pos_z, output ready);
endinterface

// ===== sv/frf_out_if.sv =====
// ----------------------------------------------------------------------------
// frf_out_if
// Force channel: three force components and clip flag, valid/ready handshake.
// ----------------------------------------------------------------------------
interface frf_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [frf_pkg::ForceW-1:0] force_x;
    logic signed [frf_pkg::ForceW-1:0] force_y;
    logic signed [frf_pkg::ForceW-1:0] force_z;
    logic                              saturated;

    modport source (output valid, force_x, force_y, force_z, saturated, input ready);
    modport sink   (input valid, force_x, force_y, force_z, saturated, output ready);
endinterface

// ===== sv/frf_regs.sv =====
// ----------------------------------------------------------------------------
// frf_regs
// APB register file holding the fence configuration.
// ----------------------------------------------------------------------------
module frf_regs (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [frf_pkg::AddrW-1:0]  paddr,
    input  logic [frf_pkg::DataW-1:0]  pwdata,
    output logic [frf_pkg::DataW-1:0]  prdata,
    output logic                       pready,
    output frf_pkg::cfg_t              cfg
);
    import frf_pkg::*;

    logic       wr;
    logic [2:0] idx;
    cfg_t       cfg_reg;
    cfg_t       cfg_next;

    assign wr     = psel && penable && pwrite;
    assign idx    = paddr[AddrW-1:3];
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    // register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr)
        begin
            case (idx)
                REG_MODE:   cfg_next.mode   = pwdata[0];
                REG_ID:     cfg_next.id     = pwdata[IdW-1:0];
                REG_WEIGHT: cfg_next.weight = pwdata[WtW-1:0];
                REG_RAD:    cfg_next.rad    = pwdata[RadW-1:0];
                REG_BX:     cfg_next.bnd[0] = pwdata[BndW-1:0];
                REG_BY:     cfg_next.bnd[1] = pwdata[BndW-1:0];
                REG_BZ:     cfg_next.bnd[2] = pwdata[BndW-1:0];
                default:    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mode   <= MODE_SPHERE;
            cfg_reg.id     <= '0;
            cfg_reg.weight <= WEIGHT_RST;
            cfg_reg.rad    <= '0;
            cfg_reg.bnd    <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // read mux
    always_comb
    begin
        case (idx)
            REG_MODE:   prdata = DataW'(cfg_reg.mode);
            REG_ID:     prdata = DataW'(cfg_reg.id);
            REG_WEIGHT: prdata = DataW'(cfg_reg.weight);
            REG_RAD:    prdata = DataW'(cfg_reg.rad);
            REG_BX:     prdata = DataW'(cfg_reg.bnd[0]);
            REG_BY:     prdata = DataW'(cfg_reg.bnd[1]);
            REG_BZ:     prdata = DataW'(cfg_reg.bnd[2]);
            default:    prdata = '0;
        endcase
    end

endmodule

// ===== sv/frf_front.sv =====
// ----------------------------------------------------------------------------
// frf_front
// Three front stages: offsets from center and cuboid overlap, squares and
// weight products, then the sum of squares and the finished cuboid force.
// ----------------------------------------------------------------------------
module frf_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  logic                            in_valid,
    input  logic [frf_pkg::IdW-1:0]         agent_id,
    input  logic signed [frf_pkg::PosW-1:0] pos_x,
    input  logic signed [frf_pkg::PosW-1:0] pos_y,
    input  logic signed [frf_pkg::PosW-1:0] pos_z,
    input  frf_pkg::cfg_t                   cfg,
    output logic                            v_out,
    output logic [frf_pkg::SqW-1:0]         sumsq,
    output frf_pkg::side_t                  side
);
    import frf_pkg::*;

    logic signed [PosW-1:0] pos [3];
    logic signed [PosW-1:0] lo  [3];
    logic signed [PosW-1:0] hi  [3];
    logic signed [DW-1:0]   lo_e [3];
    logic signed [DW-1:0]   hi_e [3];
    logic signed [DW-1:0]   pos_e [3];
    logic signed [DW-1:0]   ctr_sum [3];
    logic signed [DW-1:0]   ctr [3];
    logic                   match;

    // stage 1
    logic                   v1_reg;
    logic signed [DW-1:0]   d1_reg [3];
    logic [DW-1:0]          cd1_reg [3];
    logic [2:0]             below1_reg, above1_reg;
    logic                   sph1_reg, cub1_reg;
    logic signed [DW-1:0]   d1_next [3];
    logic [DW-1:0]          cd1_next [3];
    logic [2:0]             below1_next, above1_next;

    // stage 2
    logic                   v2_reg;
    logic [DW-1:0]          mag2_reg [3];
    logic [SqW-1:0]         sq2_reg [3];
    logic [ProdW-1:0]       cp2_reg [3];
    logic [2:0]             neg2_reg, below2_reg, above2_reg;
    logic                   sph2_reg, cub2_reg;
    logic [DW-1:0]          mag2_next [3];

    // stage 3
    logic                   v3_reg;
    logic [SqW-1:0]         sumsq3_reg;
    side_t                  side3_reg;
    side_t                  side3_next;
    logic [ForceW:0]        clp [3];

    assign pos[0] = pos_x;
    assign pos[1] = pos_y;
    assign pos[2] = pos_z;
    assign match  = (agent_id == cfg.id);

    // center, offset and cuboid overlap per axis
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            lo[i]      = $signed(cfg.bnd[i][PosW-1:0]);
            hi[i]      = $signed(cfg.bnd[i][BndW-1:PosW]);
            lo_e[i]    = DW'(lo[i]);
            hi_e[i]    = DW'(hi[i]);
            pos_e[i]   = DW'(pos[i]);
            ctr_sum[i] = lo_e[i] + hi_e[i];
            ctr[i]     = ctr_sum[i] >>> 1;
            d1_next[i] = pos_e[i] - ctr[i];
            below1_next[i] = pos[i] < lo[i];
            above1_next[i] = pos[i] > hi[i];
            cd1_next[i] = below1_next[i] ? DW'(lo_e[i] - pos_e[i])
                                         : DW'(pos_e[i] - hi_e[i]);
        end
    end

    // magnitudes for stage 2
    always_comb
    begin
        for (int i = 0; i < 3; i++)
            mag2_next[i] = (d1_reg[i] < 0) ? DW'(-d1_reg[i]) : DW'(d1_reg[i]);
    end

    // sum of squares and cuboid clip
    always_comb
    begin
        side3_next.sphere = sph2_reg;
        side3_next.neg    = neg2_reg;
        side3_next.sat    = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            side3_next.mag[i] = mag2_reg[i];
            clp[i] = clip_force(cp2_reg[i][ProdW-1:CubSh], 1'b0, !below2_reg[i]);
            if (cub2_reg && (below2_reg[i] || above2_reg[i]))
            begin
                side3_next.frc[i] = clp[i][ForceW-1:0];
                side3_next.sat    = side3_next.sat | clp[i][ForceW];
            end
            else
            begin
                side3_next.frc[i] = '0;
            end
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                d1_reg[i]   <= d1_next[i];
                cd1_reg[i]  <= cd1_next[i];
                mag2_reg[i] <= mag2_next[i];
                sq2_reg[i]  <= mag2_next[i] * mag2_next[i];
                cp2_reg[i]  <= cd1_reg[i] * cfg.weight;
                neg2_reg[i] <= d1_reg[i] > 0;
            end
            below1_reg <= below1_next;
            above1_reg <= above1_next;
            sph1_reg   <= !match && (cfg.mode == MODE_SPHERE);
            cub1_reg   <= !match && (cfg.mode == MODE_CUBOID);
            below2_reg <= below1_reg;
            above2_reg <= above1_reg;
            sph2_reg   <= sph1_reg;
            cub2_reg   <= cub1_reg;
            sumsq3_reg <= sq2_reg[0] + sq2_reg[1] + sq2_reg[2];
            side3_reg  <= side3_next;
        end
    end

    assign v_out = v3_reg;
    assign sumsq = sumsq3_reg;
    assign side  = side3_reg;

endmodule

// ===== sv/frf_sqrt.sv =====
// ----------------------------------------------------------------------------
// frf_sqrt
// Pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module frf_sqrt (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       v_in,
    input  logic [frf_pkg::SqW-1:0]    n_in,
    input  frf_pkg::side_t             side_in,
    output logic                       v_out,
    output logic [frf_pkg::DistW-1:0]  dist_out,
    output frf_pkg::side_t             side_out
);
    import frf_pkg::*;

    logic           v_reg    [RtSteps];
    logic [RtW-1:0] n_reg    [RtSteps];
    logic [RtW-1:0] rt_reg   [RtSteps];
    side_t          side_reg [RtSteps];

    logic           v_src    [RtSteps];
    logic [RtW-1:0] n_src    [RtSteps];
    logic [RtW-1:0] rt_src   [RtSteps];
    side_t          side_src [RtSteps];
    logic [RtW-1:0] bitv     [RtSteps];
    logic [RtW-1:0] trial    [RtSteps];
    logic [RtW-1:0] n_next   [RtSteps];
    logic [RtW-1:0] rt_next  [RtSteps];

    // stage inputs
    always_comb
    begin
        v_src[0]    = v_in;
        n_src[0]    = RtW'(n_in);
        rt_src[0]   = '0;
        side_src[0] = side_in;
        for (int k = 1; k < RtSteps; k++)
        begin
            v_src[k]    = v_reg[k-1];
            n_src[k]    = n_reg[k-1];
            rt_src[k]   = rt_reg[k-1];
            side_src[k] = side_reg[k-1];
        end
    end

    // one trial subtract per stage
    always_comb
    begin
        for (int k = 0; k < RtSteps; k++)
        begin
            bitv[k]  = RtW'(1) << (2 * (RtSteps - 1 - k));
            trial[k] = rt_src[k] + bitv[k];
            if (n_src[k] >= trial[k])
            begin
                n_next[k]  = n_src[k] - trial[k];
                rt_next[k] = (rt_src[k] >> 1) + bitv[k];
            end
            else
            begin
                n_next[k]  = n_src[k];
                rt_next[k] = rt_src[k] >> 1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < RtSteps; k++)
                v_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            for (int k = 0; k < RtSteps; k++)
                v_reg[k] <= v_src[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < RtSteps; k++)
            begin
                n_reg[k]    <= n_next[k];
                rt_reg[k]   <= rt_next[k];
                side_reg[k] <= side_src[k];
            end
        end
    end

    assign v_out    = v_reg[RtSteps-1];
    assign dist_out = rt_reg[RtSteps-1][DistW-1:0];
    assign side_out = side_reg[RtSteps-1];

endmodule

// ===== sv/frf_div.sv =====
// ----------------------------------------------------------------------------
// frf_div
// Sphere force back end: denominator and numerators, overflow check, a
// pipelined restoring divider on three lanes and the output clip stage.
// ----------------------------------------------------------------------------
module frf_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  logic                        v_in,
    input  logic [frf_pkg::DistW-1:0]   dist_in,
    input  frf_pkg::side_t              side_in,
    input  frf_pkg::cfg_t               cfg,
    output logic                        v_out,
    output logic [frf_pkg::ForceW-1:0]  frc_x,
    output logic [frf_pkg::ForceW-1:0]  frc_y,
    output logic [frf_pkg::ForceW-1:0]  frc_z,
    output logic                        sat
);
    import frf_pkg::*;

    // P1: radius test
    logic             v1_reg, act1_reg;
    logic [DistW-1:0] dist1_reg, e1_reg;
    side_t            side1_reg;

    // P2: products
    logic             v2_reg, act2_reg;
    logic [DenW-1:0]  den2_reg;
    logic [ProdW-1:0] prod2_reg [3];
    side_t            side2_reg;

    // P3: divider set-up
    logic             v3_reg, act3_reg;
    logic [DenW-1:0]  den3_reg;
    logic [DenW-1:0]  rem3_reg [3];
    logic [QW-1:0]    low3_reg [3];
    logic [2:0]       ovf3_reg;
    side_t            side3_reg;
    logic [NumW-1:0]  num3 [3];

    // divider stages
    logic             vd_reg   [QW];
    logic             actd_reg [QW];
    logic [DenW-1:0]  dend_reg [QW];
    logic [2:0]       ovfd_reg [QW];
    side_t            sided_reg [QW];
    logic [DenW-1:0]  remd_reg [QW][3];
    logic [QW-1:0]    lowd_reg [QW][3];
    logic [QW-1:0]    qd_reg   [QW][3];

    logic             vd_src   [QW];
    logic             actd_src [QW];
    logic [DenW-1:0]  dend_src [QW];
    logic [2:0]       ovfd_src [QW];
    side_t            sided_src [QW];
    logic [DenW-1:0]  remd_src [QW][3];
    logic [QW-1:0]    lowd_src [QW][3];
    logic [QW-1:0]    qd_src   [QW][3];
    logic [DenW:0]    trial    [QW][3];
    logic [DenW-1:0]  remd_next [QW][3];
    logic [QW-1:0]    qd_next   [QW][3];

    // output stage
    logic                 vo_reg;
    logic [ForceW-1:0]    fo_reg [3];
    logic                 so_reg;
    logic [ForceW-1:0]    fo_next [3];
    logic                 so_next;
    logic [ForceW:0]      clp [3];

    // dividend with fraction shift; top part decides overflow
    always_comb
    begin
        for (int i = 0; i < 3; i++)
            num3[i] = {prod2_reg[i], {FracSh{1'b0}}};
    end

    // divider stage inputs
    always_comb
    begin
        vd_src[0]    = v3_reg;
        actd_src[0]  = act3_reg;
        dend_src[0]  = den3_reg;
        ovfd_src[0]  = ovf3_reg;
        sided_src[0] = side3_reg;
        for (int i = 0; i < 3; i++)
        begin
            remd_src[0][i] = rem3_reg[i];
            lowd_src[0][i] = low3_reg[i];
            qd_src[0][i]   = '0;
        end
        for (int j = 1; j < QW; j++)
        begin
            vd_src[j]    = vd_reg[j-1];
            actd_src[j]  = actd_reg[j-1];
            dend_src[j]  = dend_reg[j-1];
            ovfd_src[j]  = ovfd_reg[j-1];
            sided_src[j] = sided_reg[j-1];
            for (int i = 0; i < 3; i++)
            begin
                remd_src[j][i] = remd_reg[j-1][i];
                lowd_src[j][i] = lowd_reg[j-1][i];
                qd_src[j][i]   = qd_reg[j-1][i];
            end
        end
    end

    // one quotient bit per stage and lane
    always_comb
    begin
        for (int j = 0; j < QW; j++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                trial[j][i] = {remd_src[j][i], lowd_src[j][i][QW-1]};
                if (trial[j][i] >= {1'b0, dend_src[j]})
                begin
                    remd_next[j][i] = DenW'(trial[j][i] - {1'b0, dend_src[j]});
                    qd_next[j][i]   = {qd_src[j][i][QW-2:0], 1'b1};
                end
                else
                begin
                    remd_next[j][i] = DenW'(trial[j][i]);
                    qd_next[j][i]   = {qd_src[j][i][QW-2:0], 1'b0};
                end
            end
        end
    end

    // clip and merge with the cuboid/zero result
    always_comb
    begin
        so_next = actd_reg[QW-1] ? 1'b0 : sided_reg[QW-1].sat;
        for (int i = 0; i < 3; i++)
        begin
            clp[i] = clip_force(qd_reg[QW-1][i], ovfd_reg[QW-1][i],
                                sided_reg[QW-1].neg[i]);
            if (actd_reg[QW-1])
            begin
                fo_next[i] = clp[i][ForceW-1:0];
                so_next    = so_next | clp[i][ForceW];
            end
            else
            begin
                fo_next[i] = sided_reg[QW-1].frc[i];
            end
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            vo_reg <= 1'b0;
            for (int j = 0; j < QW; j++)
                vd_reg[j] <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= v_in;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            for (int j = 0; j < QW; j++)
                vd_reg[j] <= vd_src[j];
            vo_reg <= vd_reg[QW-1];
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            act1_reg  <= side_in.sphere && (dist_in > DistW'(cfg.rad));
            dist1_reg <= dist_in;
            e1_reg    <= dist_in - DistW'(cfg.rad);
            side1_reg <= side_in;

            act2_reg  <= act1_reg;
            den2_reg  <= dist1_reg * e1_reg;
            side2_reg <= side1_reg;

            act3_reg  <= act2_reg;
            den3_reg  <= den2_reg;
            side3_reg <= side2_reg;

            for (int i = 0; i < 3; i++)
            begin
                prod2_reg[i] <= side1_reg.mag[i] * cfg.weight;
                ovf3_reg[i]  <= DenW'(num3[i][NumW-1:QW]) >= den2_reg;
                rem3_reg[i]  <= DenW'(num3[i][NumW-1:QW]);
                low3_reg[i]  <= num3[i][QW-1:0];
            end

            for (int j = 0; j < QW; j++)
            begin
                actd_reg[j]  <= actd_src[j];
                dend_reg[j]  <= dend_src[j];
                ovfd_reg[j]  <= ovfd_src[j];
                sided_reg[j] <= sided_src[j];
                for (int i = 0; i < 3; i++)
                begin
                    remd_reg[j][i] <= remd_next[j][i];
                    lowd_reg[j][i] <= lowd_src[j][i] << 1;
                    qd_reg[j][i]   <= qd_next[j][i];
                end
            end

            for (int i = 0; i < 3; i++)
                fo_reg[i] <= fo_next[i];
            so_reg <= so_next;
        end
    end

    assign v_out = vo_reg;
    assign frc_x = fo_reg[0];
    assign frc_y = fo_reg[1];
    assign frc_z = fo_reg[2];
    assign sat   = so_reg;

endmodule

// ===== sv/fence_repel_force_top.sv =====
// ----------------------------------------------------------------------------
// fence_repel_force_top
// Repelling force of a sphere or cuboid fence on one agent per transfer.
//
//   channel  | dir | handshake        | payload
//   ---------+-----+------------------+-------------------------------------
//   in_ch    | in  | valid / ready    | agent_id, pos_x, pos_y, pos_z
//   out_ch   | out | valid / ready    | force_x, force_y, force_z, saturated
//   apb      | in  | psel/penable     | paddr, pwdata, prdata, pready
//
// One transfer in and one out per cycle while out_ch is not stalled. The path
// holds 3 front stages, 25 square-root stages, 3 set-up stages, 33 divider
// stages and the output register; the root and quotient bit counts set these.
// Reset clears all valid bits and loads the register defaults.
// A stall on out_ch freezes the whole pipeline; in_ch.ready follows it.
// ----------------------------------------------------------------------------
module fence_repel_force_top (
    input  logic                       clk,
    input  logic                       rst_n,
    frf_in_if.sink                     in_ch,
    frf_out_if.source                  out_ch,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [frf_pkg::AddrW-1:0]  paddr,
    input  logic [frf_pkg::DataW-1:0]  pwdata,
    output logic [frf_pkg::DataW-1:0]  prdata,
    output logic                       pready
);
    import frf_pkg::*;

    cfg_t             cfg;
    logic             en;
    logic             fr_v, sq_v, dv_v;
    logic [SqW-1:0]   sumsq;
    side_t            fr_side, sq_side;
    logic [DistW-1:0] sq_dist;
    logic [ForceW-1:0] fx, fy, fz;
    logic             sat;

    // global advance: output register empty or being drained
    assign en          = !dv_v || out_ch.ready;
    assign in_ch.ready = en;

    frf_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    frf_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .in_valid (in_ch.valid),
        .agent_id (in_ch.agent_id),
        .pos_x    (in_ch.pos_x),
        .pos_y    (in_ch.pos_y),
        .pos_z    (in_ch.pos_z),
        .cfg      (cfg),
        .v_out    (fr_v),
        .sumsq    (sumsq),
        .side     (fr_side)
    );

    frf_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .v_in     (fr_v),
        .n_in     (sumsq),
        .side_in  (fr_side),
        .v_out    (sq_v),
        .dist_out (sq_dist),
        .side_out (sq_side)
    );

    frf_div u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .v_in    (sq_v),
        .dist_in (sq_dist),
        .side_in (sq_side),
        .cfg     (cfg),
        .v_out   (dv_v),
        .frc_x   (fx),
        .frc_y   (fy),
        .frc_z   (fz),
        .sat     (sat)
    );

    assign out_ch.valid     = dv_v;
    assign out_ch.force_x   = $signed(fx);
    assign out_ch.force_y   = $signed(fy);
    assign out_ch.force_z   = $signed(fz);
    assign out_ch.saturated = sat;

endmodule

// ===== sv/frf_checker.sv =====
// ----------------------------------------------------------------------------
// frf_checker
// Port-level checks for the fence repel force block, bound to the top level.
// ----------------------------------------------------------------------------
module frf_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [frf_pkg::ForceW-1:0]  force_x,
    input logic [frf_pkg::ForceW-1:0]  force_y,
    input logic [frf_pkg::ForceW-1:0]  force_z,
    input logic                        saturated
);
    import frf_pkg::*;

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(force_x) &&
        $stable(force_y) && $stable(force_z) && $stable(saturated))
        else $error("stalled result changed");

    // input side advances exactly when the output register can move
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |-> (in_ready == (!out_valid || out_ready)))
        else $error("in ready does not track output drain");

    // clip flag only with a component at a rail
    a_sat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |->
            (force_x == FMAX || force_x == FMIN || force_y == FMAX ||
             force_y == FMIN || force_z == FMAX || force_z == FMIN))
        else $error("saturated without a clipped component");

endmodule

bind fence_repel_force_top frf_checker u_frf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .force_x   (out_ch.force_x),
    .force_y   (out_ch.force_y),
    .force_z   (out_ch.force_z),
    .saturated (out_ch.saturated)
);

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for fence_repel_force_top. A queue of agent items feeds
// a driver; every transfer in is run through a local force predictor and every
// force transfer out is checked against the oldest prediction. Phases cover
// sphere and cuboid fences, register extremes and several idle/stall mixes.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import frf_pkg::*;

    typedef struct {
        logic [IdW-1:0]  id;
        logic [PosW-1:0] px;
        logic [PosW-1:0] py;
        logic [PosW-1:0] pz;
    } agent_t;

    typedef struct {
        logic [ForceW-1:0] fx;
        logic [ForceW-1:0] fy;
        logic [ForceW-1:0] fz;
        logic              sat;
    } force_t;

    localparam int WatchLimit = 20000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [AddrW-1:0] paddr = '0;
    logic [DataW-1:0] pwdata = '0;
    logic [DataW-1:0] prdata;
    logic pready;

    frf_in_if  in_ch();
    frf_out_if out_ch();

    fence_repel_force_top DUT (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #4 clk = ~clk;

    // local copy of the fence registers
    logic              fence_mode_q = MODE_SPHERE;
    logic [IdW-1:0]    fence_id_q   = '0;
    logic [WtW-1:0]    weight_q     = WEIGHT_RST;
    logic [RadW-1:0]   rad_q        = '0;
    logic [BndW-1:0]   bnd_q [3]    = '{default: '0};

    agent_t pending_agents[$];
    force_t expected_forces[$];
    int     errors = 0;
    int     send_idle_pct = 0;
    int     recv_stall_pct = 0;
    bit     hold_go = 1'b0;
    bit     took = 1'b0;
    int     quiet_cycles = 0;

    // ------------------------------------------------------------------------
    // force predictor
    function automatic longint unsigned int_sqrt(input longint unsigned n);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (n >= root + bitv)
            begin
                n = n - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    // {clipped, word}
    function automatic logic [ForceW:0] sat_word(input longint unsigned mag,
                                                 input bit neg);
        if (neg)
        begin
            if (mag > 64'h8000_0000)
                return {1'b1, FMIN};
            return {1'b0, 32'(64'd0 - mag)};
        end
        if (mag > 64'h7FFF_FFFF)
            return {1'b1, FMAX};
        return {1'b0, mag[ForceW-1:0]};
    endfunction

    function automatic force_t fence_force(input agent_t a);
        force_t r;
        longint pos [3];
        longint off [3];
        longint lo, hi, s;
        longint unsigned m, sumsq, dlen, den, num;
        logic [ForceW:0] w [3];
        pos[0] = longint'(signed'(a.px));
        pos[1] = longint'(signed'(a.py));
        pos[2] = longint'(signed'(a.pz));
        w = '{default: '0};
        sumsq = 0;
        if (a.id != fence_id_q)
        begin
            if (fence_mode_q == MODE_SPHERE)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    lo = longint'(signed'(bnd_q[i][23:0]));
                    hi = longint'(signed'(bnd_q[i][47:24]));
                    s = lo + hi;
                    off[i] = pos[i] - (s >>> 1);
                    m = (off[i] < 0) ? -off[i] : off[i];
                    sumsq += m * m;
                end
                dlen = int_sqrt(sumsq);
                if (dlen > rad_q)
                begin
                    den = dlen * (dlen - rad_q);
                    for (int i = 0; i < 3; i++)
                    begin
                        m = (off[i] < 0) ? -off[i] : off[i];
                        num = (m * weight_q) << 16;
                        w[i] = sat_word(num / den, off[i] > 0);
                    end
                end
            end
            else
            begin
                for (int i = 0; i < 3; i++)
                begin
                    lo = longint'(signed'(bnd_q[i][23:0]));
                    hi = longint'(signed'(bnd_q[i][47:24]));
                    if (pos[i] < lo)
                        w[i] = sat_word(((lo - pos[i]) * weight_q) >> 8, 1'b0);
                    else if (pos[i] > hi)
                        w[i] = sat_word(((pos[i] - hi) * weight_q) >> 8, 1'b1);
                end
            end
        end
        r.fx = w[0][ForceW-1:0];
        r.fy = w[1][ForceW-1:0];
        r.fz = w[2][ForceW-1:0];
        r.sat = w[0][ForceW] | w[1][ForceW] | w[2][ForceW];
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // agent driver: valid holds until the transfer
    always @(posedge clk)
    begin
        took <= rst_n && in_ch.valid && in_ch.ready;
        if (rst_n && in_ch.valid && in_ch.ready)
        begin
            expected_forces.push_back(fence_force(pending_agents[0]));
            void'(pending_agents.pop_front());
        end
    end

    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.agent_id = '0;
        in_ch.pos_x = '0;
        in_ch.pos_y = '0;
        in_ch.pos_z = '0;
    end

    always @(negedge clk)
    begin
        if (in_ch.valid && !took)
            ; // still waiting for the transfer
        else if (rst_n && pending_agents.size() > 0
                 && $urandom_range(99) >= send_idle_pct)
        begin
            in_ch.valid = 1'b1;
            in_ch.agent_id = pending_agents[0].id;
            in_ch.pos_x = pending_agents[0].px;
            in_ch.pos_y = pending_agents[0].py;
            in_ch.pos_z = pending_agents[0].pz;
        end
        else
            in_ch.valid = 1'b0;
    end

    // ------------------------------------------------------------------------
    // force receiver, with a long hold-off on request
    int  hold_left = 0;
    bit  hold_seen = 1'b0;
    initial out_ch.ready = 1'b0;

    always @(negedge clk)
    begin
        if (hold_go && !hold_seen)
            hold_left = 400;
        hold_seen = hold_go;
        if (hold_left > 0)
        begin
            hold_left--;
            out_ch.ready = 1'b0;
        end
        else
            out_ch.ready = ($urandom_range(99) >= recv_stall_pct);
    end

    // force checker
    always @(posedge clk)
    begin
        force_t e;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_forces.size() == 0)
            begin
                $display("%0t: unexpected force transfer x=%h y=%h z=%h sat=%b", $time,
                         out_ch.force_x, out_ch.force_y, out_ch.force_z, out_ch.saturated);
                errors++;
            end
            else
            begin
                e = expected_forces.pop_front();
                if (out_ch.force_x !== e.fx)
                begin
                    $display("%0t: force_x expected %h actual %h", $time, e.fx, out_ch.force_x);
                    errors++;
                end
                if (out_ch.force_y !== e.fy)
                begin
                    $display("%0t: force_y expected %h actual %h", $time, e.fy, out_ch.force_y);
                    errors++;
                end
                if (out_ch.force_z !== e.fz)
                begin
                    $display("%0t: force_z expected %h actual %h", $time, e.fz, out_ch.force_z);
                    errors++;
                end
                if (out_ch.saturated !== e.sat)
                begin
                    $display("%0t: saturated expected %b actual %b", $time, e.sat,
                             out_ch.saturated);
                    errors++;
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WatchLimit)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus
    task automatic reg_write(input logic [2:0] idx, input logic [DataW-1:0] val);
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 3'b000};
        pwdata = val;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        case (idx)
            REG_MODE:   fence_mode_q = val[0];
            REG_ID:     fence_id_q = val[IdW-1:0];
            REG_WEIGHT: weight_q = val[WtW-1:0];
            REG_RAD:    rad_q = val[RadW-1:0];
            REG_BX:     bnd_q[0] = val[BndW-1:0];
            REG_BY:     bnd_q[1] = val[BndW-1:0];
            REG_BZ:     bnd_q[2] = val[BndW-1:0];
            default:    ;
        endcase
    endtask

    task automatic set_fence(input logic mode, input logic [IdW-1:0] id,
                             input logic [WtW-1:0] wt, input logic [RadW-1:0] rad,
                             input logic [BndW-1:0] bx, input logic [BndW-1:0] by,
                             input logic [BndW-1:0] bz);
        reg_write(REG_MODE, 64'(mode));
        reg_write(REG_ID, 64'(id));
        reg_write(REG_WEIGHT, 64'(wt));
        reg_write(REG_RAD, 64'(rad));
        reg_write(REG_BX, 64'(bx));
        reg_write(REG_BY, 64'(by));
        reg_write(REG_BZ, 64'(bz));
    endtask

    task automatic add_agent(input logic [IdW-1:0] id, input logic [PosW-1:0] x,
                             input logic [PosW-1:0] y, input logic [PosW-1:0] z);
        agent_t a;
        a.id = id;
        a.px = x;
        a.py = y;
        a.pz = z;
        pending_agents.push_back(a);
    endtask

    // point near the fence surface (sphere) or the box faces (cuboid)
    function automatic logic [PosW-1:0] near_axis(input int i, input bit on_axis);
        longint lo, hi, c, v;
        lo = longint'(signed'(bnd_q[i][23:0]));
        hi = longint'(signed'(bnd_q[i][47:24]));
        if (fence_mode_q == MODE_SPHERE)
        begin
            c = (lo + hi) >>> 1;
            v = on_axis ? longint'(rad_q) + $urandom_range(0, 40)
                        : longint'($urandom_range(0, 40)) - 20;
            v = $urandom_range(1) ? c + v : c - v;
        end
        else
        begin
            v = $urandom_range(1) ? lo : hi;
            v = v + longint'($urandom_range(0, 600)) - 300;
        end
        return v[PosW-1:0];
    endfunction

    task automatic add_random(input int n);
        int ax;
        logic [IdW-1:0] id;
        for (int k = 0; k < n; k++)
        begin
            id = ($urandom_range(9) == 0) ? fence_id_q : IdW'($urandom);
            if ($urandom_range(99) < 60)
            begin
                ax = $urandom_range(2);
                add_agent(id, near_axis(0, ax == 0), near_axis(1, ax == 1),
                          near_axis(2, ax == 2));
            end
            else
                add_agent(id, PosW'($urandom), PosW'($urandom), PosW'($urandom));
        end
    endtask

    task automatic drain(input int extra);
        wait (pending_agents.size() == 0 && expected_forces.size() == 0);
        repeat (extra) @(posedge clk);
    endtask

    task automatic set_idling(input int phase);
        case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 64; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 64; end
            default: begin send_idle_pct = 18; recv_stall_pct = 18; end
        endcase
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: reset registers, sphere at origin, id 0 matches
        add_agent(16'h0000, 24'h001000, 24'h0, 24'h0);
        add_agent(16'h0001, 24'h0, 24'h0, 24'h0);
        add_agent(16'hFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
        add_agent(16'h0002, 24'h800000, 24'h800000, 24'h800000);
        add_agent(16'h0003, 24'h000001, 24'h0, 24'h0);
        add_agent(16'h0004, 24'h0, 24'hFFFFFF, 24'h0);
        add_agent(16'h0005, 24'h0, 24'h0, 24'h7FFFFF);
        add_agent(16'h0006, 24'h800000, 24'h7FFFFF, 24'h000001);
        drain(70);
        // cuboid, inverted x bounds, full gain to hit clipping both ways
        set_fence(MODE_CUBOID, 16'h00AA, 16'hFFFF, 23'h0,
                  {24'hFFF000, 24'h001000}, {24'h7FFFFF, 24'h800000}, 48'h0);
        add_agent(16'h00AA, 24'h7FFFFF, 24'h800000, 24'h7FFFFF);
        add_agent(16'h00AB, 24'h000000, 24'h0, 24'h7FFFFF);
        add_agent(16'h00AB, 24'h002000, 24'h0, 24'h800000);
        add_agent(16'h00AB, 24'hFFE000, 24'h0, 24'h000001);
        add_agent(16'h00AB, 24'h001000, 24'h0, 24'h0);
        // sphere: agent at center, just outside the radius, tiny gap
        drain(70);
        set_fence(MODE_SPHERE, 16'h0, 16'hFFFF, 23'h001000,
                  {24'h003000, 24'h003000}, {24'hFFF000, 24'hFFF000}, 48'h0);
        add_agent(16'h0001, 24'h003000, 24'hFFF000, 24'h0);
        add_agent(16'h0001, 24'h004001, 24'hFFF000, 24'h0);
        add_agent(16'h0001, 24'h003000, 24'hFFDFFF, 24'h0);
        add_agent(16'h0001, 24'h7FFFFF, 24'h800000, 24'h7FFFFF);
        drain(70);

        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph)
                0: set_fence(MODE_SPHERE, 16'h0005, 16'h0100, 23'h0,
                             48'h0, 48'h0, 48'h0);
                1: set_fence(MODE_SPHERE, 16'hFFFF, 16'hFFFF, 23'h001000,
                             {24'h0003E8, 24'h0003E8}, {24'hFFFC18, 24'hFFFC18},
                             {24'h000007, 24'h000007});
                2: set_fence(MODE_SPHERE, 16'h5A5A, 16'h00CD, 23'h7FFFFF,
                             48'hFFFF_FFFF_FFFF, {24'h000000, 24'hFFFFFD},
                             {24'h7FFFFF, 24'h800000});
                3: set_fence(MODE_CUBOID, 16'hA5A5, 16'h0100, 23'h0,
                             {24'h00A000, 24'hFF6000}, {24'h001000, 24'hFFF000},
                             {24'h100000, 24'h000000});
                4: set_fence(MODE_CUBOID, 16'h0000, 16'hFFFF, 23'h2AAAAA,
                             {24'hFF0000, 24'h010000}, {24'h000000, 24'h000100},
                             48'hFFFF_FFFF_FFFF);
                5: set_fence(MODE_CUBOID, 16'h1234, 16'h0000, 23'h555555,
                             {24'h7FFFFF, 24'h800000}, 48'h0, {24'h000400, 24'h000400});
                6: set_fence(MODE_SPHERE, 16'h00FF, 16'h00CD, 23'h000064,
                             {24'h7FFFFF, 24'h800000}, {24'h7FFFFF, 24'h7FFFFF},
                             {24'h800000, 24'h800000});
                default: set_fence(MODE_CUBOID, 16'hFF00, 16'h00CD, 23'h0,
                                   {24'h7FFFFF, 24'h7FFFFF}, {24'h800000, 24'h800000},
                                   {24'h555555, 24'hAAAAAA});
            endcase
            set_idling(ph);
            add_random(150);
            // receiver holds off while the sender keeps offering
            if (ph == 1)
            begin
                hold_go = 1'b1;
                add_random(60);
            end
            add_random(60);
            drain(70);
            hold_go = 1'b0;
        end

        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
